// ===== rtl/assert_macros.svh =====
// Assertion helpers. All use clk_i and rst_ni of the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define KLT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define KLT_ASSERT_NOW(label, ante, cons, msg) \
  `KLT_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define KLT_ASSERT_NEXT(label, ante, cons, msg) \
  `KLT_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== rtl/klt_pkg.sv =====
`default_nettype none

package klt_pkg;

  // Default widths of the line/column and length counters.
  localparam int unsigned POS_BITS_DEF = 16;
  localparam int unsigned LEN_BITS_DEF = 16;

  // Result queue geometry: one input can cause up to three tokens.
  localparam int unsigned MAX_PUSH  = 3;
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned PTR_BITS  = $clog2(RES_DEPTH);
  localparam int unsigned CNT_BITS  = $clog2(RES_DEPTH + 1);
  localparam int unsigned PUSH_BITS = $clog2(MAX_PUSH + 1);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_OP      = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_STR     = 3'd3,
    MODE_INT     = 3'd4,
    MODE_DOT     = 3'd5,
    MODE_FRAC    = 3'd6,
    MODE_IDENT   = 3'd7
  } scan_mode_e;

  // Token kinds.
  localparam logic [4:0] KIND_EOF      = 5'd0;
  localparam logic [4:0] KIND_LPAREN   = 5'd1;
  localparam logic [4:0] KIND_RPAREN   = 5'd2;
  localparam logic [4:0] KIND_PLUS     = 5'd3;
  localparam logic [4:0] KIND_MINUS    = 5'd4;
  localparam logic [4:0] KIND_STAR     = 5'd5;
  localparam logic [4:0] KIND_COMMA    = 5'd6;
  localparam logic [4:0] KIND_LBRACE   = 5'd7;
  localparam logic [4:0] KIND_RBRACE   = 5'd8;
  localparam logic [4:0] KIND_ASSIGN   = 5'd9;
  localparam logic [4:0] KIND_EQ       = 5'd10;
  localparam logic [4:0] KIND_LT       = 5'd11;
  localparam logic [4:0] KIND_LE       = 5'd12;
  localparam logic [4:0] KIND_GT       = 5'd13;
  localparam logic [4:0] KIND_GE       = 5'd14;
  localparam logic [4:0] KIND_SLASH    = 5'd15;
  localparam logic [4:0] KIND_NEWLINE  = 5'd16;
  localparam logic [4:0] KIND_STRING   = 5'd17;
  localparam logic [4:0] KIND_NUMBER   = 5'd18;
  localparam logic [4:0] KIND_IDENT    = 5'd19;
  localparam logic [4:0] KIND_KW_FIRST = 5'd20;
  localparam logic [4:0] KIND_BAD      = 5'd25;
  localparam logic [4:0] KIND_UNTERM   = 5'd26;

  // Control bytes.
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // Keywords, right-justified in 9-byte words.
  localparam int unsigned NUM_KW = 5;
  localparam logic [71:0] KW_TEXT [NUM_KW] = '{
    "declare", "function", "return", "repeat", "condition"
  };
  localparam int unsigned KW_LEN [NUM_KW] = '{7, 8, 6, 6, 9};

  // Byte idx of keyword k; zero past its end.
  function automatic logic [7:0] kw_char(input int unsigned k, input logic [3:0] idx);
    int unsigned sh;
    logic [7:0]  ch;
    ch = 8'h00;
    if (32'(idx) < KW_LEN[k]) begin
      sh = (KW_LEN[k] - 1 - 32'(idx)) * 8;
      ch = KW_TEXT[k][sh +: 8];
    end
    return ch;
  endfunction

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_col;
    logic [15:0] text_length;
    logic [7:0]  bad_char;
    logic        last_of_run;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/klt_res_fifo.sv =====
`default_nettype none

`include "assert_macros.svh"

module klt_res_fifo (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire  [klt_pkg::PUSH_BITS-1:0]      push_cnt_i,
  input  klt_pkg::res_t                      push_data_i [klt_pkg::MAX_PUSH],
  output logic                               room_o,
  output logic                               valid_o,
  input  wire                                ready_i,
  output klt_pkg::res_t                      data_o
);

  localparam int unsigned PtrBits  = klt_pkg::PTR_BITS;
  localparam int unsigned CntBits  = klt_pkg::CNT_BITS;
  localparam int unsigned PushBits = klt_pkg::PUSH_BITS;

  klt_pkg::res_t        mem_q [klt_pkg::RES_DEPTH];
  logic [PtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;
  // room for a full burst of results
  assign room_o  = (cnt_q <= CntBits'(klt_pkg::RES_DEPTH - klt_pkg::MAX_PUSH));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrBits'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + PtrBits'(pop);
    cnt_d    = cnt_q + CntBits'(push_cnt_i) - CntBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < klt_pkg::MAX_PUSH; i++) begin
      if (PushBits'(i) < push_cnt_i) begin
        mem_q[wr_ptr_q + PtrBits'(i)] <= push_data_i[i];
      end
    end
  end

  `KLT_ASSERT_NOW(a_push_fits, push_cnt_i != '0, room_o, "result burst pushed without room")
  `KLT_ASSERT(a_cnt_bound, cnt_q <= CntBits'(klt_pkg::RES_DEPTH), "result count over depth")

endmodule

`default_nettype wire

// ===== rtl/keyword_lexer_tokenizer.sv =====
`default_nettype none

// Streaming lexical scanner. Each input transfer carries one source byte
// (req_type_i = 0) or the end-of-source mark (req_type_i = 1). A transfer
// causes zero to three token transfers on the output: a pending token that
// the byte ends (a number ended by a dot gives two, the number and a bad-char
// token for the dot), then any token the byte starts, or on end of source the
// EOF token, after which the scanner is back in its reset state.
// last_of_run_o marks the last token caused by one input transfer.
// Timing: every input byte is handled as it is transferred; its tokens enter a
// four-entry result queue at the next edge and leave at one per cycle while
// out_ready_i is high, so the first token of a byte can be taken the cycle
// after the byte's transfer. in_ready_o is high while the queue has room for
// three results (at most one token waiting). Sustained rate is one byte per
// cycle while each byte causes at most one token and the output is taken
// every cycle; a byte that causes two or three tokens lifts the queue above
// one entry and holds in_ready_o low while the queue drains. Line, column and
// length counters are POS_BITS / LEN_BITS wide, saturate, and are shown in
// their low 16 bits.

`include "assert_macros.svh"

module keyword_lexer_tokenizer #(
  parameter int unsigned POS_BITS = klt_pkg::POS_BITS_DEF,
  parameter int unsigned LEN_BITS = klt_pkg::LEN_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // byte stream in
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire         req_type_i,
  input  wire  [7:0]  char_byte_i,
  // tokens out
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [4:0]  token_kind_o,
  output logic [15:0] start_line_o,
  output logic [15:0] start_col_o,
  output logic [15:0] text_length_o,
  output logic [7:0]  bad_char_o,
  output logic        last_of_run_o
);

  localparam logic [POS_BITS-1:0] PosMax = '1;
  localparam logic [LEN_BITS-1:0] LenMax = '1;
  localparam logic [POS_BITS-1:0] PosOne = POS_BITS'(1);
  localparam int unsigned PushBits = klt_pkg::PUSH_BITS;

  // ---------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------
  function automatic logic [15:0] pos16(input logic [POS_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  function automatic logic [15:0] len16(input logic [LEN_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  // saturating length add of 1 or 2
  function automatic logic [LEN_BITS-1:0] len_add(input logic [LEN_BITS-1:0] v,
                                                  input logic [1:0] step);
    logic [LEN_BITS:0] s;
    s = {1'b0, v} + (LEN_BITS+1)'(step);
    return (s > {1'b0, LenMax}) ? LenMax : s[LEN_BITS-1:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic klt_pkg::res_t mk_res(input logic [4:0]          kind,
                                           input logic [POS_BITS-1:0] ln,
                                           input logic [POS_BITS-1:0] col,
                                           input logic [LEN_BITS-1:0] len,
                                           input logic [7:0]          bad);
    klt_pkg::res_t r;
    r.token_kind  = kind;
    r.start_line  = pos16(ln);
    r.start_col   = pos16(col);
    r.text_length = len16(len);
    r.bad_char    = bad;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Scanner state
  // ---------------------------------------------------------------------
  klt_pkg::scan_mode_e  mode_q, mode_d;
  logic [POS_BITS-1:0]  cur_line_q, cur_line_d;
  logic [POS_BITS-1:0]  cur_col_q, cur_col_d;
  logic [POS_BITS-1:0]  tok_line_q, tok_line_d;
  logic [POS_BITS-1:0]  tok_col_q, tok_col_d;
  logic [LEN_BITS-1:0]  tok_len_q, tok_len_d;
  logic [4:0]           kw_hits_q, kw_hits_d;
  logic [7:0]           held_q, held_d;

  logic                 in_fire;
  logic [7:0]           c;

  // flush of the pending token
  logic [1:0]           fl_n;
  klt_pkg::res_t        fl0, fl1;
  logic                 use_flush;
  logic                 fresh;
  logic                 do_start;
  // token made by this byte (or EOF)
  logic                 tail_v;
  klt_pkg::res_t        tail;

  logic [4:0]           op_one, op_two, id_kind;
  logic [32:0]          dot_sum;
  logic [POS_BITS-1:0]  dot_col;

  logic [PushBits-1:0]  push_cnt;
  logic [1:0]           fl_use;
  klt_pkg::res_t        push_data [klt_pkg::MAX_PUSH];
  logic                 room;

  assign in_ready_o = room;
  assign in_fire    = in_valid_i && in_ready_o;
  assign c          = char_byte_i;

  // Operator kinds for the held byte.
  always_comb begin
    case (held_q)
      "=":     begin op_one = klt_pkg::KIND_ASSIGN; op_two = klt_pkg::KIND_EQ; end
      "<":     begin op_one = klt_pkg::KIND_LT;     op_two = klt_pkg::KIND_LE; end
      ">":     begin op_one = klt_pkg::KIND_GT;     op_two = klt_pkg::KIND_GE; end
      default: begin op_one = klt_pkg::KIND_SLASH;  op_two = klt_pkg::KIND_SLASH; end
    endcase
  end

  // Identifier kind: first keyword still matching at full length.
  always_comb begin
    id_kind = klt_pkg::KIND_IDENT;
    for (int k = klt_pkg::NUM_KW - 1; k >= 0; k--) begin
      if (kw_hits_q[k] && (tok_len_q == LEN_BITS'(klt_pkg::KW_LEN[k]))) begin
        id_kind = 5'(32'(klt_pkg::KIND_KW_FIRST) + 32'(k));
      end
    end
  end

  // Column of a dot that ended a number.
  assign dot_sum = 33'(tok_col_q) + 33'(tok_len_q);
  assign dot_col = (dot_sum > 33'(PosMax)) ? PosMax : dot_sum[POS_BITS-1:0];

  // What the pending token turns into when something ends it.
  always_comb begin
    fl_n = 2'd0;
    fl0  = mk_res(klt_pkg::KIND_EOF, tok_line_q, tok_col_q, '0, 8'h00);
    fl1  = mk_res(klt_pkg::KIND_BAD, tok_line_q, dot_col, LEN_BITS'(1), ".");
    unique case (mode_q) inside
      klt_pkg::MODE_OP: begin
        fl_n = 2'd1;
        fl0  = mk_res(op_one, tok_line_q, tok_col_q, LEN_BITS'(1), 8'h00);
      end
      klt_pkg::MODE_STR: begin
        fl_n = 2'd1;
        fl0  = mk_res(klt_pkg::KIND_UNTERM, tok_line_q, tok_col_q, tok_len_q, 8'h00);
      end
      klt_pkg::MODE_INT, klt_pkg::MODE_FRAC: begin
        fl_n = 2'd1;
        fl0  = mk_res(klt_pkg::KIND_NUMBER, tok_line_q, tok_col_q, tok_len_q, 8'h00);
      end
      klt_pkg::MODE_DOT: begin
        fl_n = 2'd2;
        fl0  = mk_res(klt_pkg::KIND_NUMBER, tok_line_q, tok_col_q, tok_len_q, 8'h00);
      end
      klt_pkg::MODE_IDENT: begin
        fl_n = 2'd1;
        fl0  = mk_res(id_kind, tok_line_q, tok_col_q, tok_len_q, 8'h00);
      end
      default: fl_n = 2'd0;
    endcase
  end

  // Next state and the token made by this transfer.
  always_comb begin
    mode_d     = mode_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    tok_len_d  = tok_len_q;
    kw_hits_d  = kw_hits_q;
    held_d     = held_q;
    use_flush  = 1'b0;
    fresh      = 1'b0;
    do_start   = 1'b0;
    tail_v     = 1'b0;
    tail       = mk_res(klt_pkg::KIND_EOF, cur_line_q, cur_col_q, '0, 8'h00);

    if (in_fire && req_type_i) begin
      // end of source: flush, EOF, back to reset state
      use_flush  = 1'b1;
      tail_v     = 1'b1;
      mode_d     = klt_pkg::MODE_IDLE;
      cur_line_d = PosOne;
      cur_col_d  = PosOne;
      tok_line_d = PosOne;
      tok_col_d  = PosOne;
      tok_len_d  = '0;
      kw_hits_d  = '1;
      held_d     = 8'h00;
    end else if (in_fire) begin
      unique case (mode_q)
        klt_pkg::MODE_OP: begin
          if (held_q == "/") begin
            if (c == "/") mode_d = klt_pkg::MODE_COMMENT;
            else          fresh  = 1'b1;
          end else if (c == "=") begin
            tail_v = 1'b1;
            tail   = mk_res(op_two, tok_line_q, tok_col_q, LEN_BITS'(2), 8'h00);
            mode_d = klt_pkg::MODE_IDLE;
          end else begin
            fresh = 1'b1;
          end
        end
        klt_pkg::MODE_COMMENT: begin
          if (c == klt_pkg::CH_LF) fresh = 1'b1;
        end
        klt_pkg::MODE_STR: begin
          if (c == "\"") begin
            tail_v = 1'b1;
            tail   = mk_res(klt_pkg::KIND_STRING, tok_line_q, tok_col_q, tok_len_q, 8'h00);
            mode_d = klt_pkg::MODE_IDLE;
          end else begin
            tok_len_d = len_add(tok_len_q, 2'd1);
          end
        end
        klt_pkg::MODE_INT: begin
          if (is_digit(c))   tok_len_d = len_add(tok_len_q, 2'd1);
          else if (c == ".") mode_d    = klt_pkg::MODE_DOT;
          else               fresh     = 1'b1;
        end
        klt_pkg::MODE_DOT: begin
          if (is_digit(c)) begin
            tok_len_d = len_add(tok_len_q, 2'd2);
            mode_d    = klt_pkg::MODE_FRAC;
          end else begin
            fresh = 1'b1;
          end
        end
        klt_pkg::MODE_FRAC: begin
          if (is_digit(c)) tok_len_d = len_add(tok_len_q, 2'd1);
          else             fresh     = 1'b1;
        end
        klt_pkg::MODE_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            for (int k = 0; k < klt_pkg::NUM_KW; k++) begin
              kw_hits_d[k] = kw_hits_q[k]
                             && (tok_len_q < LEN_BITS'(klt_pkg::KW_LEN[k]))
                             && (klt_pkg::kw_char(k, tok_len_q[3:0]) == c);
            end
            tok_len_d = len_add(tok_len_q, 2'd1);
          end else begin
            fresh = 1'b1;
          end
        end
        default: ;  // idle: byte starts a token below
      endcase

      use_flush = fresh;
      do_start  = fresh || (mode_q == klt_pkg::MODE_IDLE);

      if (do_start) begin
        mode_d     = klt_pkg::MODE_IDLE;
        tok_line_d = cur_line_q;
        tok_col_d  = cur_col_q;
        tok_len_d  = '0;
        tail       = mk_res(klt_pkg::KIND_BAD, cur_line_q, cur_col_q, LEN_BITS'(1), 8'h00);
        case (c) inside
          "(": begin tail_v = 1'b1; tail.token_kind = klt_pkg::KIND_LPAREN; end
          ")": begin tail_v = 1'b1; tail.token_kind = klt_pkg::KIND_RPAREN; end
          "+": begin tail_v = 1'b1; tail.token_kind = klt_pkg::KIND_PLUS;   end
          "-": begin tail_v = 1'b1; tail.token_kind = klt_pkg::KIND_MINUS;  end
          "*": begin tail_v = 1'b1; tail.token_kind = klt_pkg::KIND_STAR;   end
          ",": begin tail_v = 1'b1; tail.token_kind = klt_pkg::KIND_COMMA;  end
          "{": begin tail_v = 1'b1; tail.token_kind = klt_pkg::KIND_LBRACE; end
          "}": begin tail_v = 1'b1; tail.token_kind = klt_pkg::KIND_RBRACE; end
          "=", "<", ">", "/": begin
            mode_d = klt_pkg::MODE_OP;
            held_d = c;
          end
          klt_pkg::CH_LF: begin
            tail_v          = 1'b1;
            tail.token_kind = klt_pkg::KIND_NEWLINE;
          end
          " ", klt_pkg::CH_CR, klt_pkg::CH_TAB: ;
          "\"": mode_d = klt_pkg::MODE_STR;
          ["0":"9"]: begin
            mode_d    = klt_pkg::MODE_INT;
            tok_len_d = len_add('0, 2'd1);
          end
          ["a":"z"], ["A":"Z"], "_": begin
            mode_d = klt_pkg::MODE_IDENT;
            for (int k = 0; k < klt_pkg::NUM_KW; k++) begin
              kw_hits_d[k] = (klt_pkg::kw_char(k, 4'd0) == c);
            end
            tok_len_d = len_add('0, 2'd1);
          end
          default: begin
            tail_v        = 1'b1;
            tail.bad_char = c;
          end
        endcase
      end

      // position of the next byte
      if (c == klt_pkg::CH_LF) begin
        if (cur_line_q < PosMax) cur_line_d = cur_line_q + PosOne;
        cur_col_d = PosOne;
      end else if (cur_col_q < PosMax) begin
        cur_col_d = cur_col_q + PosOne;
      end
    end
  end

  // Order the burst: flushed tokens first, then this byte's token.
  always_comb begin
    fl_use   = use_flush ? fl_n : 2'd0;
    push_cnt = PushBits'(fl_use) + PushBits'(tail_v);
    push_data[0] = (fl_use != 2'd0) ? fl0 : tail;
    push_data[1] = (fl_use == 2'd2) ? fl1 : tail;
    push_data[2] = tail;
    for (int i = 0; i < klt_pkg::MAX_PUSH; i++) begin
      push_data[i].last_of_run = (PushBits'(i + 1) == push_cnt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= klt_pkg::MODE_IDLE;
      cur_line_q <= PosOne;
      cur_col_q  <= PosOne;
      tok_line_q <= PosOne;
      tok_col_q  <= PosOne;
      tok_len_q  <= '0;
      kw_hits_q  <= '1;
      held_q     <= 8'h00;
    end else begin
      mode_q     <= mode_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      tok_len_q  <= tok_len_d;
      kw_hits_q  <= kw_hits_d;
      held_q     <= held_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------
  klt_pkg::res_t out_data;

  klt_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push_data_i(push_data),
    .room_o     (room),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .data_o     (out_data)
  );

  assign token_kind_o  = out_data.token_kind;
  assign start_line_o  = out_data.start_line;
  assign start_col_o   = out_data.start_col;
  assign text_length_o = out_data.text_length;
  assign bad_char_o    = out_data.bad_char;
  assign last_of_run_o = out_data.last_of_run;

  // Only a number ended by a dot can yield a three-token burst.
  `KLT_ASSERT_NOW(a_burst3_dot, push_cnt == PushBits'(3), mode_q == klt_pkg::MODE_DOT,
                  "three-token burst outside dot mode")
  // End of source puts the scanner back at line 1, column 1, idle.
  `KLT_ASSERT_NEXT(a_eof_reset, in_fire && req_type_i,
                   mode_q == klt_pkg::MODE_IDLE && cur_line_q == PosOne && cur_col_q == PosOne,
                   "scanner not reset after end of source")

endmodule

`default_nettype wire
